// ----- rtl/jht_pkg.sv -----
// Types, codes and constants shared by the joystick hysteresis trigger.
`default_nettype none

package jht_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int LEVEL_W    = 12;
    localparam int LOCKOUT_W  = 24;
    localparam int TIME_W     = 48;
    localparam int CENTER_W   = 12;
    localparam int DEFL_W     = 13;
    localparam int ALU_W      = TIME_W + 1;

    localparam logic [1:0] REQ_CAL    = 2'd0;
    localparam logic [1:0] REQ_FINISH = 2'd1;
    localparam logic [1:0] REQ_RUN    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_US  = 2'd2;

    localparam logic [LEVEL_W-1:0]   OPEN_LEVEL_RST  = 12'd566;
    localparam logic [LEVEL_W-1:0]   CLOSE_LEVEL_RST = 12'd227;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_US_RST  = 24'd300000;
    localparam logic [CENTER_W-1:0]  CENTER_RST      = 12'd2048;
    localparam logic [CENTER_W-1:0]  CENTER_MAX      = 12'hFFF;

    localparam logic signed [DEFL_W-1:0] SPAN_POS = 13'sd1888;
    localparam logic signed [DEFL_W-1:0] SPAN_NEG = -13'sd1888;

    typedef struct packed {
        logic [1:0]        req_type;
        logic              pos_valid;
        logic [7:0]        y_pos;
        logic              button_valid;
        logic [7:0]        button_value;
        logic [TIME_W-1:0] now_us;
    } jht_in_t;

    typedef struct packed {
        logic trigger_level;
        logic open_event;
        logic close_event;
        logic capture_event;
    } jht_out_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   open_level;
        logic [LEVEL_W-1:0]   close_level;
        logic [LOCKOUT_W-1:0] lockout_us;
    } jht_cfg_t;

    typedef struct packed {
        logic start;
        logic res_ready;
    } jht_ctl_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } jht_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_FIN,
        ST_DIV,
        ST_FIN_END,
        ST_DEFL,
        ST_LEVEL,
        ST_TIME,
        ST_LOCK,
        ST_DONE
    } jht_state_t;

endpackage

`default_nettype wire

// ----- rtl/jht_core.sv -----
// Sequencer, calibration state and shared add/subtract unit of the trigger.
`default_nettype none

module jht_core #(
    parameter int MAX_CAL_SAMPLES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  jht_pkg::jht_cfg_t cfg,
    input  jht_pkg::jht_in_t  item,
    input  jht_pkg::jht_ctl_t ctl,
    output jht_pkg::jht_sts_t sts,
    output jht_pkg::jht_out_t result
);
    import jht_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int SUM_W  = $clog2(MAX_CAL_SAMPLES * 255 + 1);
    localparam int DIV_W  = CNT_W + 1;
    localparam int NUM_W  = SUM_W + 5;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_CAL_SAMPLES);
    localparam logic [STEP_W-1:0] STEP_START = STEP_W'(NUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(1);

    jht_state_t state_reg, state_next;
    jht_in_t    item_reg, item_next;

    logic [CENTER_W-1:0] center_reg, center_next;
    logic                rest_reg, rest_next;
    logic [SUM_W-1:0]    y_sum_reg, y_sum_next;
    logic [CNT_W-1:0]    pos_count_reg, pos_count_next;
    logic [CNT_W-1:0]    zero_count_reg, zero_count_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                trig_reg, trig_next;
    logic                prev_reg, prev_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic                oe_reg, oe_next;
    logic                ce_reg, ce_next;
    logic                cap_reg, cap_next;

    logic signed [DEFL_W-1:0] d_reg, d_next;
    logic [TIME_W-1:0]        diff_reg, diff_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [STEP_W-1:0]        step_reg, step_next;

    logic [ALU_W-1:0] alu_a, alu_b, alu_y;
    logic             alu_sub;
    logic             alu_neg;

    logic [DIV_W:0]           trial;
    logic [DIV_W-1:0]         divisor;
    logic signed [DEFL_W-1:0] d_raw;
    logic                     pressed;

    assign trial   = {rem_reg, quo_reg[NUM_W-1]};
    assign divisor = {pos_count_reg, 1'b0};
    assign d_raw   = signed'(alu_y[DEFL_W-1:0]);
    assign pressed = (item_reg.button_value != {7'd0, rest_reg});

    assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
    assign alu_neg = alu_y[ALU_W-1];

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            ST_CAL:
            begin
                alu_a   = ALU_W'(y_sum_reg);
                alu_b   = ALU_W'(item_reg.y_pos);
                alu_sub = 1'b0;
            end
            ST_DIV:
            begin
                alu_a = ALU_W'(trial);
                alu_b = ALU_W'(divisor);
            end
            ST_DEFL:
            begin
                alu_a = ALU_W'(center_reg);
                alu_b = ALU_W'({item_reg.y_pos, 4'd0});
            end
            ST_LEVEL:
            begin
                if (trig_reg)
                begin
                    alu_a = {{(ALU_W-DEFL_W){d_reg[DEFL_W-1]}}, d_reg};
                    alu_b = ALU_W'(cfg.close_level);
                end
                else
                begin
                    alu_a = ALU_W'(cfg.open_level);
                    alu_b = {{(ALU_W-DEFL_W){d_reg[DEFL_W-1]}}, d_reg};
                end
            end
            ST_TIME:
            begin
                alu_a = ALU_W'(item_reg.now_us);
                alu_b = ALU_W'(last_reg);
            end
            ST_LOCK:
            begin
                alu_a = ALU_W'(cfg.lockout_us);
                alu_b = ALU_W'(diff_reg);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        center_next     = center_reg;
        rest_next       = rest_reg;
        y_sum_next      = y_sum_reg;
        pos_count_next  = pos_count_reg;
        zero_count_next = zero_count_reg;
        total_next      = total_reg;
        trig_next       = trig_reg;
        prev_next       = prev_reg;
        last_next       = last_reg;
        oe_next         = oe_reg;
        ce_next         = ce_reg;
        cap_next        = cap_reg;
        d_next          = d_reg;
        diff_next       = diff_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    item_next = item;
                    oe_next   = 1'b0;
                    ce_next   = 1'b0;
                    cap_next  = 1'b0;
                    case (item.req_type)
                        REQ_CAL:    state_next = ST_CAL;
                        REQ_FINISH: state_next = ST_FIN;
                        REQ_RUN:    state_next = item.pos_valid ? ST_DEFL : ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_CAL:
            begin
                if (item_reg.pos_valid && pos_count_reg < CNT_MAX)
                begin
                    y_sum_next     = alu_y[SUM_W-1:0];
                    pos_count_next = pos_count_reg + CNT_W'(1);
                end
                if (item_reg.button_valid && total_reg < CNT_MAX)
                begin
                    total_next = total_reg + CNT_W'(1);
                    if (item_reg.button_value == 8'd0)
                    begin
                        zero_count_next = zero_count_reg + CNT_W'(1);
                    end
                end
                state_next = ST_DONE;
            end
            ST_FIN:
            begin
                rem_next   = '0;
                quo_next   = (NUM_W'(y_sum_reg) << 5) | NUM_W'(pos_count_reg);
                step_next  = STEP_START;
                state_next = (pos_count_reg != '0) ? ST_DIV : ST_FIN_END;
            end
            ST_DIV:
            begin
                rem_next  = alu_neg ? trial[DIV_W-1:0] : alu_y[DIV_W-1:0];
                quo_next  = {quo_reg[NUM_W-2:0], ~alu_neg};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FIN_END;
                end
            end
            ST_FIN_END:
            begin
                if (pos_count_reg != '0)
                begin
                    center_next = (|quo_reg[NUM_W-1:CENTER_W]) ? CENTER_MAX
                                                               : quo_reg[CENTER_W-1:0];
                end
                if (total_reg != '0)
                begin
                    rest_next = !(zero_count_reg > (total_reg >> 1));
                end
                y_sum_next      = '0;
                pos_count_next  = '0;
                zero_count_next = '0;
                total_next      = '0;
                state_next      = ST_DONE;
            end
            ST_DEFL:
            begin
                if (d_raw > SPAN_POS)
                begin
                    d_next = SPAN_POS;
                end
                else if (d_raw < SPAN_NEG)
                begin
                    d_next = SPAN_NEG;
                end
                else
                begin
                    d_next = d_raw;
                end
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                if (alu_neg)
                begin
                    trig_next = !trig_reg;
                    oe_next   = !trig_reg;
                    ce_next   = trig_reg;
                end
                state_next = ST_DONE;
                if (item_reg.button_valid)
                begin
                    prev_next = pressed;
                    if (pressed && !prev_reg)
                    begin
                        state_next = ST_TIME;
                    end
                end
            end
            ST_TIME:
            begin
                diff_next  = alu_y[TIME_W-1:0];
                state_next = (!alu_neg && alu_y[TIME_W-1:0] != '0) ? ST_LOCK : ST_DONE;
            end
            ST_LOCK:
            begin
                if (alu_neg)
                begin
                    cap_next  = 1'b1;
                    last_next = item_reg.now_us;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ctl.res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            center_reg     <= CENTER_RST;
            rest_reg       <= 1'b1;
            y_sum_reg      <= '0;
            pos_count_reg  <= '0;
            zero_count_reg <= '0;
            total_reg      <= '0;
            trig_reg       <= 1'b0;
            prev_reg       <= 1'b0;
            last_reg       <= '0;
            oe_reg         <= 1'b0;
            ce_reg         <= 1'b0;
            cap_reg        <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            center_reg     <= center_next;
            rest_reg       <= rest_next;
            y_sum_reg      <= y_sum_next;
            pos_count_reg  <= pos_count_next;
            zero_count_reg <= zero_count_next;
            total_reg      <= total_next;
            trig_reg       <= trig_next;
            prev_reg       <= prev_next;
            last_reg       <= last_next;
            oe_reg         <= oe_next;
            ce_reg         <= ce_next;
            cap_reg        <= cap_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        d_reg    <= d_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign sts.idle      = (state_reg == ST_IDLE);
    assign sts.res_valid = (state_reg == ST_DONE);

    assign result.trigger_level = trig_reg;
    assign result.open_event    = oe_reg;
    assign result.close_event   = ce_reg;
    assign result.capture_event = cap_reg;

endmodule

`default_nettype wire

// ----- rtl/joystick_hysteresis_trigger.sv -----
// Top level of the joystick hysteresis trigger: ports, settings registers and result register.
//
//  Channel  Signals                                 Beat
//  in       in_valid, in_ready, in_data             one joystick sample or request
//  out      out_valid, out_ready, out_data          one trigger result per request
//  cfg      cfg_valid, cfg_ready, cfg_index/data    one settings register write
//
// A calibration sample goes through the calibration state, a run sample with a valid position
// through the deflection and level states and, on a new press, the time and lockout states, and
// any other request straight to its result. With positions collected, finishing calibration
// runs one shared-unit step per numerator bit, clog2(MAX_CAL_SAMPLES*255+1)+5 (16 by default).
// A waiting result sits in the output register while the next request is taken in.
// Reset is asynchronous and restores the default levels, lockout and a centre of 128.0.
`default_nettype none

module joystick_hysteresis_trigger #(
    parameter int MAX_CAL_SAMPLES = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  jht_pkg::jht_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output jht_pkg::jht_out_t                  out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jht_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jht_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jht_pkg::*;

    jht_cfg_t cfg_reg, cfg_next;
    jht_out_t out_data_reg;
    logic     out_valid_reg, out_valid_next;
    logic     load_out;

    jht_ctl_t ctl;
    jht_sts_t sts;
    jht_out_t result;

    assign cfg_ready = 1'b1;
    assign in_ready  = sts.idle;
    assign load_out  = sts.res_valid && (!out_valid_reg || out_ready);

    assign ctl.start     = in_valid && sts.idle;
    assign ctl.res_ready = load_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OPEN_LEVEL:  cfg_next.open_level  = cfg_data[LEVEL_W-1:0];
                CFG_CLOSE_LEVEL: cfg_next.close_level = cfg_data[LEVEL_W-1:0];
                CFG_LOCKOUT_US:  cfg_next.lockout_us  = cfg_data[LOCKOUT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_level  <= OPEN_LEVEL_RST;
            cfg_reg.close_level <= CLOSE_LEVEL_RST;
            cfg_reg.lockout_us  <= LOCKOUT_US_RST;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    jht_core #(
        .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (in_data),
        .ctl    (ctl),
        .sts    (sts),
        .result (result)
    );

endmodule

`default_nettype wire

// ----- rtl/jht_checker.sv -----
// Port-level checks for the joystick hysteresis trigger and their binding to the top level.
`default_nettype none

module jht_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input jht_pkg::jht_out_t out_data,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // An accepted request makes the block busy, so in_ready falls once the request is registered.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on the cycle after an accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result beat changed or vanished");

    a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.open_event && out_data.close_event))
        else $error("open and close events in one result");

    a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.open_event || out_data.close_event))
            |-> (out_data.trigger_level == out_data.open_event))
        else $error("trigger level disagrees with its event");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("settings write refused");

endmodule

bind joystick_hysteresis_trigger jht_checker u_jht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
